// ===== sv/rfac_pkg.sv =====
// Shared types and constants for the rectangle fill area counter.
// No dependencies; imported by rectangle_fill_area_counter, rfac_area_checker and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package rfac_pkg;

  // Width of one coordinate or field-size register.
  localparam int COORD_W = 9;
  // Width of the reported area and its saturation value.
  localparam int AREA_W = 17;
  localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;
  // Reset value of both field-size registers.
  localparam logic [COORD_W-1:0] FIELD_RESET = 9'd256;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FIELD_WIDTH  = 1'b0,
    CFG_FIELD_HEIGHT = 1'b1
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } rfac_state_e;

endpackage

`default_nettype wire

// ===== sv/rectangle_fill_area_counter.sv =====
// Rectangle fill area counter: row-wide occupancy memory, row sweeper,
// population count and area accumulator. Depends on rfac_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Beat payload
// -------   ---------  ----------------------  -----------------------------------------
// in        sink       in_valid_i / in_stall_o  row_first, col_first, row_last, col_last
// out       source     out_valid_o / out_stall_i marked_area
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index (0 width, 1 height), cfg_data
//
// Every item sweeps all MAX_SIDE rows of the occupancy memory through one shared
// row unit: one row is read, merged with the rectangle's column mask, written back
// and counted per cycle. The memory's single write port sets the rate, and a new
// item is accepted only once the previous one has been swept, drained and loaded.
// After reset a clearing pass writes zero to every row with in_stall_o high;
// configuration writes are taken at any time.
// The result sits in an output register, so a stalled result only holds the next
// item back once that item has finished its sweep.

module rectangle_fill_area_counter #(
  parameter int MAX_SIDE = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Rectangle input channel.
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [rfac_pkg::COORD_W-1:0] row_first_i,
  input  wire  [rfac_pkg::COORD_W-1:0] col_first_i,
  input  wire  [rfac_pkg::COORD_W-1:0] row_last_i,
  input  wire  [rfac_pkg::COORD_W-1:0] col_last_i,
  // Area result channel.
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [rfac_pkg::AREA_W-1:0]  marked_area_o,
  // Configuration write channel.
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [0:0]                   cfg_index_i,
  input  wire  [rfac_pkg::COORD_W-1:0] cfg_data_i
);

  import rfac_pkg::*;

  // Row index width, width for comparing 1-based positions against the
  // 9-bit coordinates, popcount width and accumulator width.
  localparam int IW   = $clog2(MAX_SIDE);
  localparam int CW   = (IW + 1 > COORD_W) ? IW + 1 : COORD_W;
  localparam int PW   = $clog2(MAX_SIDE + 1);
  localparam int ACCW = (2 * IW + 1 > AREA_W) ? 2 * IW + 1 : AREA_W;

  typedef logic [MAX_SIDE-1:0] row_t;

  function automatic logic [PW-1:0] popcount(input row_t v);
    logic [PW-1:0] s;
    s = '0;
    for (int k = 0; k < MAX_SIDE; k++) begin
      s = s + PW'(v[k]);
    end
    return s;
  endfunction

  // Occupancy memory, one word per row.
  row_t mem [MAX_SIDE];

  rfac_state_e state_q, state_d;
  logic [IW-1:0]      row_q;
  logic               issue;
  logic               start;
  logic               load_out;

  // Configuration registers.
  logic [COORD_W-1:0] field_width_q, field_height_q;

  // Item context captured at the accepted beat.
  row_t               rect_cols_q;
  row_t               field_cols_q;
  logic [COORD_W-1:0] row_first_q, row_last_q, rows_used_q;

  // Sweep pipeline: read data stage, then count stage.
  logic               s1_vld_q, s2_vld_q;
  logic [IW-1:0]      s1_row_q;
  row_t               rd_data_q;
  row_t               merged;
  row_t               count_bits_d, count_bits_q;
  logic [CW-1:0]      s1_pos;
  logic               s1_in_rect, s1_in_field;
  logic [ACCW-1:0]    acc_q;

  logic [AREA_W-1:0]  area_q;
  logic               out_valid_q;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign marked_area_o = area_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        row_q <= '0;
      end else if (state_q == ST_CLEAR || issue) begin
        row_q <= row_q + IW'(1);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (row_q == IW'(MAX_SIDE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          start   = 1'b1;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        issue = 1'b1;
        if (row_q == IW'(MAX_SIDE - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The accumulator is final once both pipeline stages are empty.
        if (!s1_vld_q && !s2_vld_q && (!out_valid_q || !out_stall_i)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Configuration registers, written whenever a beat arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q  <= FIELD_RESET;
      field_height_q <= FIELD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FIELD_WIDTH:  field_width_q  <= cfg_data_i;
        CFG_FIELD_HEIGHT: field_height_q <= cfg_data_i;
        default:          field_width_q  <= field_width_q;
      endcase
    end
  end

  // Column masks are built once per item. Positions are 1-based, so column
  // zero and columns past the store fall away without explicit clipping, and
  // an inverted rectangle yields an empty mask.
  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int j = 0; j < MAX_SIDE; j++) begin
        rect_cols_q[j]  <= (CW'(col_first_i) <= CW'(j + 1)) &&
                           (CW'(j + 1) <= CW'(col_last_i));
        field_cols_q[j] <= (CW'(j + 1) <= CW'(field_width_q));
      end
      row_first_q <= row_first_i;
      row_last_q  <= row_last_i;
      rows_used_q <= field_height_q;
    end
  end

  // Memory: registered read during the sweep, one write port shared by the
  // clearing pass and the write-back of merged rows.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[row_q];
    end
    if (state_q == ST_CLEAR) begin
      mem[row_q] <= '0;
    end else if (s1_vld_q) begin
      mem[s1_row_q] <= merged;
    end
  end

  // Merge stage.
  assign s1_pos      = CW'({1'b0, s1_row_q}) + CW'(1);
  assign s1_in_rect  = (CW'(row_first_q) <= s1_pos) && (s1_pos <= CW'(row_last_q));
  assign s1_in_field = (s1_pos <= CW'(rows_used_q));
  assign merged       = rd_data_q | (s1_in_rect ? rect_cols_q : '0);
  assign count_bits_d = merged & field_cols_q & {MAX_SIDE{s1_in_field}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (start) begin
        acc_q <= '0;
      end else if (s2_vld_q) begin
        acc_q <= acc_q + ACCW'(popcount(count_bits_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q     <= row_q;
    count_bits_q <= count_bits_d;
  end

  // Output register; the area saturates at the top of the 17-bit range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      area_q <= (acc_q > ACCW'(AREA_MAX)) ? AREA_MAX : acc_q[AREA_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // A new item never starts while rows of the previous one are in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!s1_vld_q && !s2_vld_q))
    else $error("item accepted with sweep pipeline busy");

  // The count stage is only fed from the merge stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> $past(s1_vld_q))
    else $error("count stage valid without merge stage");

  // A result appears only at the end of a drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DRAIN))
    else $error("result produced outside drain");

  // The accumulator can never exceed the number of cells in the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ACCW'(MAX_SIDE * MAX_SIDE))
    else $error("area accumulator beyond store size");
`endif

endmodule

`default_nettype wire

// ===== dv/rfac_area_checker.sv =====
// Scoreboard for the rectangle fill area counter: mirrors the occupancy map,
// predicts the area of every accepted rectangle and compares the area beats.
// Depends on rfac_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module rfac_area_checker
  import rfac_pkg::*;
#(
  parameter int SIDE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [COORD_W-1:0]   row_first_i,
  input  logic [COORD_W-1:0]   col_first_i,
  input  logic [COORD_W-1:0]   row_last_i,
  input  logic [COORD_W-1:0]   col_last_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic [AREA_W-1:0]    marked_area_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  logic [SIDE-1:0]    occupancy [SIDE];
  logic [COORD_W-1:0] field_w;
  logic [COORD_W-1:0] field_h;
  logic [AREA_W-1:0]  area_due [$];
  logic [AREA_W-1:0]  want;

  // Marks the clipped rectangle, then recounts the whole current field.
  function automatic logic [AREA_W-1:0] area_after_rect(input logic [COORD_W-1:0] r_lo,
                                                        input logic [COORD_W-1:0] c_lo,
                                                        input logic [COORD_W-1:0] r_hi,
                                                        input logic [COORD_W-1:0] c_hi);
    int r0, c0, r1, c1, rows, cols, sum;
    logic [SIDE-1:0] span;
    r0 = (r_lo < 1) ? 1 : int'(r_lo);
    c0 = (c_lo < 1) ? 1 : int'(c_lo);
    r1 = (r_hi > SIDE) ? SIDE : int'(r_hi);
    c1 = (c_hi > SIDE) ? SIDE : int'(c_hi);
    if (r0 <= r1 && c0 <= c1) begin
      span = '0;
      for (int c = c0; c <= c1; c++) span[c-1] = 1'b1;
      for (int r = r0; r <= r1; r++) occupancy[r-1] |= span;
    end
    rows = (field_h > SIDE) ? SIDE : int'(field_h);
    cols = (field_w > SIDE) ? SIDE : int'(field_w);
    span = '0;
    for (int c = 0; c < cols; c++) span[c] = 1'b1;
    sum = 0;
    for (int r = 0; r < rows; r++) sum += $countones(occupancy[r] & span);
    return (sum > int'(AREA_MAX)) ? AREA_MAX : sum[AREA_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SIDE; r++) occupancy[r] = '0;
      field_w = FIELD_RESET;
      field_h = FIELD_RESET;
      area_due.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIELD_WIDTH:  field_w = cfg_data_i;
          CFG_FIELD_HEIGHT: field_h = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        area_due.push_back(area_after_rect(row_first_i, col_first_i, row_last_i, col_last_i));
      if (out_valid_o && !out_stall_i) begin
        if (area_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: area beat %0d with no rectangle outstanding", $realtime,
                     marked_area_o);
        end else begin
          want = area_due.pop_front();
          if (marked_area_o !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: marked_area expected %0d, got %0d", $realtime, want,
                       marked_area_o);
          end
        end
      end
    end
    pending_o = area_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the rectangle fill area counter testbench: clock, reset, rectangle
// and configuration stimulus, output stalls and the verdict.
// Depends on rfac_pkg, rectangle_fill_area_counter and rfac_area_checker.
`timescale 1ns / 1ps

module tb_top;
  import rfac_pkg::*;

  localparam int MAX_SIDE = 256;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 195;
  // The store side as a coordinate value.
  localparam logic [COORD_W-1:0] SIDE_C = COORD_W'(MAX_SIDE);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [COORD_W-1:0]  row_first_i = '0;
  logic [COORD_W-1:0]  col_first_i = '0;
  logic [COORD_W-1:0]  row_last_i = '0;
  logic [COORD_W-1:0]  col_last_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AREA_W-1:0]   marked_area_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i = CFG_FIELD_WIDTH;
  logic [COORD_W-1:0]  cfg_data_i = '0;

  int mismatches;
  int pending;
  // When set, neither the rectangle source nor the area sink leaves any gap,
  // so some stretches of the run go at the block's full rate.
  bit calm = 1'b0;

  always #10 clk_i = ~clk_i;

  rectangle_fill_area_counter #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_first_i  (row_first_i),
    .col_first_i  (col_first_i),
    .row_last_i   (row_last_i),
    .col_last_i   (col_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .marked_area_o(marked_area_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  rfac_area_checker #(
    .SIDE(MAX_SIDE)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_first_i  (row_first_i),
    .col_first_i  (col_first_i),
    .row_last_i   (row_last_i),
    .col_last_i   (col_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .marked_area_o(marked_area_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Length of an idle gap in cycles. Most gaps are empty or short, a few are
  // long enough to land anywhere inside the block's row sweep.
  function automatic int pick_idle();
    int p;
    p = $urandom_range(0, 99);
    if (calm) return 0;
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one rectangle beat and returns at the edge where it is taken.
  // The valid is lowered only for a real gap, so a back-to-back beat keeps it
  // high without a second assignment in the same time step.
  task automatic send_rect(input logic [COORD_W-1:0] r0, input logic [COORD_W-1:0] c0,
                           input logic [COORD_W-1:0] r1, input logic [COORD_W-1:0] c1);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_first_i <= r0;
    col_first_i <= c0;
    row_last_i  <= r1;
    col_last_i  <= c1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until every rectangle sent so far has returned its area. The count
  // is looked at on the falling edge, well clear of the checker's update.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes both field registers back to back, keeping the valid high across
  // the two beats.
  task automatic set_field(input logic [COORD_W-1:0] width, input logic [COORD_W-1:0] height);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FIELD_WIDTH;
    cfg_data_i  <= width;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_FIELD_HEIGHT;
    cfg_data_i  <= height;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Picks one random rectangle. Most are small blocks so that the map fills
  // slowly and the area keeps moving through the whole run. The rest are
  // inverted (empty) rectangles, full-span strips that exercise the clipping
  // at both ends, and raw 9-bit noise kept narrow in one direction so it
  // cannot flood the map.
  task automatic next_rect(output logic [COORD_W-1:0] r0, output logic [COORD_W-1:0] c0,
                           output logic [COORD_W-1:0] r1, output logic [COORD_W-1:0] c1);
    int kind;
    int lo;
    int hi;
    kind = $urandom_range(0, 99);
    r0 = COORD_W'($urandom_range(1, MAX_SIDE));
    c0 = COORD_W'($urandom_range(1, MAX_SIDE));
    r1 = r0 + COORD_W'($urandom_range(0, 7));
    c1 = c0 + COORD_W'($urandom_range(0, 7));
    if (kind >= 80 && kind < 90) begin
      lo = $urandom_range(1, MAX_SIDE - 1);
      hi = $urandom_range(lo + 1, MAX_SIDE);
      if (kind[0]) begin
        r0 = COORD_W'(hi);
        r1 = COORD_W'(lo);
      end else begin
        c0 = COORD_W'(hi);
        c1 = COORD_W'(lo);
      end
    end else if (kind >= 90 && kind < 93) begin
      if (kind[0]) begin
        r0 = COORD_W'($urandom_range(0, 1));
        r1 = ($urandom_range(0, 1) != 0) ? SIDE_C : 9'h1FF;
        c1 = c0;
      end else begin
        c0 = COORD_W'($urandom_range(0, 1));
        c1 = ($urandom_range(0, 1) != 0) ? SIDE_C : 9'h1FF;
        r1 = r0;
      end
    end else if (kind >= 93) begin
      r0 = COORD_W'($urandom_range(0, 511));
      c0 = COORD_W'($urandom_range(0, 511));
      r1 = COORD_W'($urandom_range(0, 511));
      c1 = COORD_W'($urandom_range(0, 511));
      if (kind[0]) c1 = c0 + COORD_W'($urandom_range(0, 3));
      else r1 = r0 + COORD_W'($urandom_range(0, 3));
    end
  endtask

  // The output stall runs on its own, independent of the rectangle source.
  initial begin
    int idle;
    @(posedge rst_ni);
    forever begin
      idle = pick_idle();
      if (idle > 0) begin
        out_stall_i <= 1'b1;
        repeat (idle) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    logic [COORD_W-1:0] r0, c0, r1, c1;
    logic [COORD_W-1:0] width, height;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the field at its reset size of 256 by 256.
    // The four corner cells come first, each adding exactly one cell.
    send_rect(1, 1, 1, 1);
    send_rect(SIDE_C, SIDE_C, SIDE_C, SIDE_C);
    send_rect(1, SIDE_C, 1, SIDE_C);
    send_rect(SIDE_C, 1, SIDE_C, 1);
    // Coordinate zero clips to one, coordinates past the store clip to the
    // last row or column; both of these collapse to empty rectangles.
    send_rect(0, 0, 0, 0);
    send_rect(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
    // Empty rectangles: rows inverted, columns inverted, both inverted.
    send_rect(5, 5, 4, 9);
    send_rect(5, 9, 9, 5);
    send_rect(9'h1FF, 9'h1FF, 0, 0);
    // Full-height and full-width strips reached through clipping, then exact.
    send_rect(0, 10, 9'h1FF, 10);
    send_rect(20, 0, 20, 9'h1FF);
    send_rect(1, 1, SIDE_C, 1);
    send_rect(SIDE_C, 1, SIDE_C, SIDE_C);
    // A mid-field block, an overlapping one, and alternating bit patterns.
    send_rect(100, 100, 163, 163);
    send_rect(150, 150, 170, 170);
    send_rect(9'h0AA, 9'h055, 9'h0AB, 9'h056);
    send_rect(9'h155, 9'h0AA, 9'h0AA, 9'h155);

    // Random phases. Each one sets the field while the block is idle. The list
    // covers the empty field in each direction, the single cell, the largest
    // register value (treated as the whole store) and a few odd shapes, so
    // marks made under one field are recounted once a later field takes them in.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin width = 1;        height = 1;        end
        1: begin width = 0;        height = SIDE_C;   end
        2: begin width = SIDE_C;   height = 0;        end
        3: begin width = 9'h1FF;   height = 9'h1FF;   end
        4: begin width = 17;       height = 200;      end
        5: begin width = SIDE_C;   height = SIDE_C;   end
        6: begin width = 1;        height = SIDE_C;   end
        7: begin width = SIDE_C;   height = 1;        end
        default: begin
          width  = COORD_W'($urandom_range(2, MAX_SIDE + 10));
          height = COORD_W'($urandom_range(2, MAX_SIDE + 10));
        end
      endcase
      set_field(width, height);
      calm = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_rect(r0, c0, r1, c1);
        send_rect(r0, c0, r1, c1);
      end
    end
    calm = 1'b0;

    // Closing part: fill the whole store through clipped bounds, then look at
    // the full map through the oversized field and through a single cell.
    drain();
    set_field(SIDE_C, SIDE_C);
    send_rect(0, 0, 9'h1FF, 9'h1FF);
    drain();
    set_field(9'h1FF, 9'h1FF);
    send_rect(0, 0, 0, 0);
    drain();
    set_field(1, 1);
    send_rect(1, 1, 1, 1);

    drain();
    repeat (MAX_SIDE + 8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: a few times the slowest correct run, which is about 2000 beats
  // of a full sweep with the longest source gap and sink stall each.
  initial begin
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rfac_pkg.sv
sv/rectangle_fill_area_counter.sv
dv/rfac_area_checker.sv
dv/tb_top.sv
